>>> sv/http_header_byte_parser_top_assert.svh
// Assertion macros for the HTTP header byte parser checker.
`ifndef HTTP_HEADER_BYTE_PARSER_TOP_ASSERT_SVH
`define HTTP_HEADER_BYTE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define HHBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define HHBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hhbp_pkg.sv
// Shared types and codes for the HTTP header byte parser.
`timescale 1ns / 1ps
`default_nettype none

package hhbp_pkg;

    // Width of the value offset and its limit register
    localparam int OFFSET_W = 10;

    // Reset value of the value offset limit
    localparam logic [OFFSET_W-1:0] MAX_OFFSET_RESET = 10'd255;

    // Framing characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Byte classes
    localparam logic [2:0] KIND_FRAME = 3'd0;
    localparam logic [2:0] KIND_KEY   = 3'd1;
    localparam logic [2:0] KIND_VALUE = 3'd2;
    localparam logic [2:0] KIND_BODY  = 3'd3;
    localparam logic [2:0] KIND_DROP  = 3'd4;

    // Parser status codes
    localparam logic [1:0] STATUS_PARSING = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    // Parser states, one-hot
    typedef enum logic [9:0] {
        ST_START  = 10'b00_0000_0001,
        ST_KEY    = 10'b00_0000_0010,
        ST_COLON  = 10'b00_0000_0100,
        ST_SPACE  = 10'b00_0000_1000,
        ST_VALUE  = 10'b00_0001_0000,
        ST_CR     = 10'b00_0010_0000,
        ST_LF     = 10'b00_0100_0000,
        ST_END_CR = 10'b00_1000_0000,
        ST_DONE   = 10'b01_0000_0000,
        ST_ERROR  = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

>>> sv/http_header_byte_parser_top.sv
// Top level of the HTTP header byte parser: byte classifier with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Classifies the header section of an HTTP request one byte per clock while the result
// channel is not stalled: every accepted byte comes back on the result channel with its
// class (framing, key, value, body or dropped), key and value end strobes and the parser
// status. The block takes one byte every cycle and keeps doing so while results flow out;
// an accepted byte is held in the input register, classified by the state machine, and
// registered into the result register, where it is presented. While the result register
// is stalled the input register still takes one more byte. Errors and the end of the
// headers are sticky until a byte arrives with restart set. The user must write the value
// length limit register through cfg_wr_en and cfg_wr_data only while no byte is in flight;
// the block itself does not enforce this, and the register resets to 255.
module http_header_byte_parser_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [hhbp_pkg::OFFSET_W-1:0] cfg_wr_data,
    // Input byte channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          restart,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         byte_out,
    output logic [2:0]                         byte_kind,
    output logic                               key_done,
    output logic                               value_done,
    output logic [1:0]                         status
);

    // Input register
    logic                          in_valid_reg,   in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          in_restart_reg;

    // Result register
    logic                          out_valid_reg,  out_valid_next;
    logic [7:0]                    byte_out_reg;
    logic [2:0]                    byte_kind_reg;
    logic                          key_done_reg;
    logic                          value_done_reg;
    logic [1:0]                    status_reg;

    // Parser state and limit
    hhbp_pkg::state_t              state_reg,      state_next;
    logic [hhbp_pkg::OFFSET_W-1:0] offset_reg,     offset_next;
    logic [hhbp_pkg::OFFSET_W-1:0] max_offset_reg;

    // Classifier signals
    hhbp_pkg::state_t              cur_state;
    logic [hhbp_pkg::OFFSET_W-1:0] cur_offset;
    logic [hhbp_pkg::OFFSET_W:0]   offset_inc;
    logic                          bad_key_start;
    logic                          is_cr;
    logic                          is_lf;
    logic [2:0]                    kind_next;
    logic                          key_done_next;
    logic                          value_done_next;
    logic [1:0]                    status_next;

    logic                          in_accept;
    logic                          advance;

    // Move the input item to the result register when that register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Apply restart before the byte is classified
    assign cur_state  = in_restart_reg ? hhbp_pkg::ST_START : state_reg;
    assign cur_offset = in_restart_reg ? '0 : offset_reg;
    assign offset_inc = {1'b0, cur_offset} + {{hhbp_pkg::OFFSET_W{1'b0}}, 1'b1};

    assign is_cr         = (in_byte_reg == hhbp_pkg::CH_CR);
    assign is_lf         = (in_byte_reg == hhbp_pkg::CH_LF);
    assign bad_key_start = (in_byte_reg == hhbp_pkg::CH_COLON) || is_cr || is_lf;

    // Classify the byte and pick the next state
    always_comb
    begin
        state_next      = cur_state;
        offset_next     = cur_offset;
        kind_next       = hhbp_pkg::KIND_FRAME;
        key_done_next   = 1'b0;
        value_done_next = 1'b0;
        case (cur_state)
            hhbp_pkg::ST_START:
            begin
                if (!(is_cr || is_lf))
                begin
                    if (bad_key_start)
                    begin
                        state_next = hhbp_pkg::ST_ERROR;
                        kind_next  = hhbp_pkg::KIND_DROP;
                    end
                    else
                    begin
                        state_next = hhbp_pkg::ST_KEY;
                        kind_next  = hhbp_pkg::KIND_KEY;
                    end
                end
            end
            hhbp_pkg::ST_KEY:
            begin
                // A key is never empty here: it was opened by a key byte
                if (in_byte_reg == hhbp_pkg::CH_COLON)
                begin
                    key_done_next = 1'b1;
                    state_next    = hhbp_pkg::ST_COLON;
                end
                else if (is_cr || is_lf)
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
                else
                begin
                    kind_next = hhbp_pkg::KIND_KEY;
                end
            end
            hhbp_pkg::ST_COLON:
            begin
                if (in_byte_reg == hhbp_pkg::CH_SPACE)
                begin
                    state_next = hhbp_pkg::ST_SPACE;
                end
                else
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
            end
            hhbp_pkg::ST_SPACE:
            begin
                if (is_cr)
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
                else
                begin
                    offset_next = '0;
                    state_next  = hhbp_pkg::ST_VALUE;
                    kind_next   = hhbp_pkg::KIND_VALUE;
                end
            end
            hhbp_pkg::ST_VALUE:
            begin
                if (is_cr)
                begin
                    value_done_next = 1'b1;
                    state_next      = hhbp_pkg::ST_CR;
                end
                else if (offset_inc > {1'b0, max_offset_reg})
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
                else
                begin
                    offset_next = offset_inc[hhbp_pkg::OFFSET_W-1:0];
                    kind_next   = hhbp_pkg::KIND_VALUE;
                end
            end
            hhbp_pkg::ST_CR:
            begin
                if (is_lf)
                begin
                    state_next = hhbp_pkg::ST_LF;
                end
                else
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
            end
            hhbp_pkg::ST_LF:
            begin
                if (is_cr)
                begin
                    state_next = hhbp_pkg::ST_END_CR;
                end
                else if (bad_key_start)
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
                else
                begin
                    state_next = hhbp_pkg::ST_KEY;
                    kind_next  = hhbp_pkg::KIND_KEY;
                end
            end
            hhbp_pkg::ST_END_CR:
            begin
                if (is_lf)
                begin
                    state_next = hhbp_pkg::ST_DONE;
                end
                else
                begin
                    state_next = hhbp_pkg::ST_ERROR;
                    kind_next  = hhbp_pkg::KIND_DROP;
                end
            end
            hhbp_pkg::ST_DONE:
            begin
                kind_next = hhbp_pkg::KIND_BODY;
            end
            default:
            begin
                // Error is sticky: drop every byte
                state_next = hhbp_pkg::ST_ERROR;
                kind_next  = hhbp_pkg::KIND_DROP;
            end
        endcase
    end

    // Report status from the state after this byte
    always_comb
    begin
        if (state_next == hhbp_pkg::ST_ERROR)
        begin
            status_next = hhbp_pkg::STATUS_ERROR;
        end
        else if (state_next == hhbp_pkg::ST_DONE)
        begin
            status_next = hhbp_pkg::STATUS_DONE;
        end
        else
        begin
            status_next = hhbp_pkg::STATUS_PARSING;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= hhbp_pkg::ST_START;
            offset_reg     <= '0;
            max_offset_reg <= hhbp_pkg::MAX_OFFSET_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg  <= state_next;
                offset_reg <= offset_next;
            end
            if (cfg_wr_en)
            begin
                max_offset_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg    <= data_byte;
            in_restart_reg <= restart;
        end
        if (advance)
        begin
            byte_out_reg   <= in_byte_reg;
            byte_kind_reg  <= kind_next;
            key_done_reg   <= key_done_next;
            value_done_reg <= value_done_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_out   = byte_out_reg;
    assign byte_kind  = byte_kind_reg;
    assign key_done   = key_done_reg;
    assign value_done = value_done_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

>>> sv/hhbp_checker.sv
// Port-level checker for the HTTP header byte parser and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "http_header_byte_parser_top_assert.svh"

module hhbp_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] byte_out,
    input wire logic [2:0] byte_kind,
    input wire logic       key_done,
    input wire logic       value_done,
    input wire logic [1:0] status
);

    // Hold a stalled item
    `HHBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(byte_out) && $stable(byte_kind) && $stable(status), "stalled result item changed")

    // Key end only on a colon framing byte while parsing
    `HHBP_ASSERT_SAME(a_key_done, out_valid && key_done, byte_out == hhbp_pkg::CH_COLON && byte_kind == hhbp_pkg::KIND_FRAME && status == hhbp_pkg::STATUS_PARSING && !value_done, "key end on wrong byte")

    // Value end only on a CR framing byte while parsing
    `HHBP_ASSERT_SAME(a_value_done, out_valid && value_done, byte_out == hhbp_pkg::CH_CR && byte_kind == hhbp_pkg::KIND_FRAME && status == hhbp_pkg::STATUS_PARSING, "value end on wrong byte")

    // Dropped bytes and error status go together
    `HHBP_ASSERT_SAME(a_drop_error, out_valid && (byte_kind == hhbp_pkg::KIND_DROP || status == hhbp_pkg::STATUS_ERROR), byte_kind == hhbp_pkg::KIND_DROP && status == hhbp_pkg::STATUS_ERROR, "drop and error status disagree")

    // Body bytes only after the headers are complete
    `HHBP_ASSERT_SAME(a_body_done, out_valid && byte_kind == hhbp_pkg::KIND_BODY, status == hhbp_pkg::STATUS_DONE, "body byte before end of headers")

endmodule

bind http_header_byte_parser_top hhbp_checker u_hhbp_checker (.*);

`default_nettype wire
